[rtl/lspg_pkg.sv]
// Shared types, register codes and color helpers for the LED strip pattern generator.
`timescale 1ns / 1ps

package lspg_pkg;

	// Default strip length along one spoke
	localparam int DEF_PIXELS_PER_SPOKE = 60;

	// Field widths
	localparam int PIX_W   = 6;
	localparam int KNOB_W  = 12;
	localparam int RGB_W   = 24;
	localparam int CHAN_W  = 8;
	localparam int PHASE_W = 8;

	// Pattern modes
	localparam logic [2:0] MODE_CYCLE   = 3'd0;
	localparam logic [2:0] MODE_STRIPE  = 3'd1;
	localparam logic [2:0] MODE_RAINBOW = 3'd2;
	localparam logic [2:0] MODE_SINGLE  = 3'd3;
	localparam logic [2:0] MODE_QUAD    = 3'd4;
	localparam logic [2:0] MODE_ROTATE  = 3'd5;
	localparam logic [2:0] MODE_HUE     = 3'd6;
	localparam logic [2:0] MODE_MANUAL  = 3'd7;

	// Register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_COUNT  = 3'd1;
	localparam logic [2:0] REG_COLOR0 = 3'd2;
	localparam logic [2:0] REG_COLOR1 = 3'd3;
	localparam logic [2:0] REG_COLOR2 = 3'd4;
	localparam logic [2:0] REG_COLOR3 = 3'd5;

	// Color channel codes inside a packed RGB word
	localparam logic [1:0] CH_BLUE  = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_RED   = 2'd2;

	// Configuration seen by the frame sequencer
	typedef struct packed {
		logic [2:0]             mode;
		logic [2:0]             count;
		logic [3:0][RGB_W-1:0]  palette;
	} cfg_t;

	// One channel blend request to the shared blend unit
	typedef struct packed {
		logic              valid;
		logic [CHAN_W-1:0] a;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] amt;
		logic [1:0]        spoke;
		logic [1:0]        chan;
	} blend_req_t;

	// Registered blend result, tagged with its destination
	typedef struct packed {
		logic              valid;
		logic [CHAN_W-1:0] value;
		logic [1:0]        spoke;
		logic [1:0]        chan;
	} blend_rsp_t;

	// Palette entries in use: zero counts as one, above four saturates
	function automatic logic [2:0] used_count(input logic [2:0] raw);
		logic [2:0] c;
		if (raw == 3'd0) begin
			c = 3'd1;
		end else if (raw > 3'd4) begin
			c = 3'd4;
		end else begin
			c = raw;
		end
		return c;
	endfunction

	// Small value reduced modulo a palette count of 1..4
	function automatic logic [1:0] mod_cnt(input logic [2:0] v, input logic [2:0] cnt);
		logic [1:0] r;
		case (cnt)
			3'd1: r = 2'd0;
			3'd2: r = {1'b0, v[0]};
			3'd3: begin
				case (v)
					3'd0, 3'd3, 3'd6: r = 2'd0;
					3'd1, 3'd4, 3'd7: r = 2'd1;
					default:          r = 2'd2;
				endcase
			end
			default: r = v[1:0];
		endcase
		return r;
	endfunction

	// Three-segment color wheel over 0..255
	function automatic logic [RGB_W-1:0] wheel(input logic [7:0] w);
		logic [7:0] v;
		logic [7:0] v3;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		if (w < 8'd85) begin
			v = w;
		end else if (w < 8'd170) begin
			v = w - 8'd85;
		end else begin
			v = w - 8'd170;
		end
		v3 = 8'({1'b0, v, 1'b0} + {2'b0, v});
		if (w < 8'd85) begin
			r = v3;
			g = 8'd255 - v3;
			b = 8'd0;
		end else if (w < 8'd170) begin
			r = 8'd255 - v3;
			g = 8'd0;
			b = v3;
		end else begin
			r = 8'd0;
			g = v3;
			b = 8'd255 - v3;
		end
		return {r, g, b};
	endfunction

endpackage

[rtl/led_strip_pattern_generator.sv]
// LED strip pattern generator for four spokes. Each input item is a frame request
// with a 12-bit knob reading; the block answers with one item per pixel position
// (0 to PIXELS_PER_SPOKE-1), each carrying the four spoke colors, and marks the last
// one with tlast. Mode and a palette of up to four colors are set over APB. For each
// frame the single shared multiplier first blends one color channel of one spoke per
// cycle, a flush state drains it, then pixels go through the output register one per
// cycle unless the output stalls, and the sequencer returns to idle to take the next
// request.
`timescale 1ns / 1ps

module led_strip_pattern_generator import lspg_pkg::*; #(
	parameter int PIXELS_PER_SPOKE = DEF_PIXELS_PER_SPOKE
) (
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// Frame requests
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [15:0]  s_axis_tdata,   // [11:0] knob_value
	// Pixel items
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,   // [5:0] pixel_position, [29:6] spoke0_rgb,
	                                     // [53:30] spoke1_rgb, [77:54] spoke2_rgb,
	                                     // [101:78] spoke3_rgb
	output logic         m_axis_tlast    // frame_end
);

	cfg_t                  cfg;
	logic                  mode_wr;
	blend_req_t            blend_req;
	blend_rsp_t            blend_rsp;
	logic [PIX_W-1:0]      out_pix;
	logic [3:0][RGB_W-1:0] out_rgb;

	lspg_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.mode_wr (mode_wr)
	);

	lspg_blend_unit u_blend_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (blend_req),
		.rsp    (blend_rsp)
	);

	lspg_frame_seq #(
		.PIXELS_PER_SPOKE (PIXELS_PER_SPOKE)
	) u_frame_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mode_wr   (mode_wr),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_knob   (s_axis_tdata[KNOB_W-1:0]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pix   (out_pix),
		.out_rgb   (out_rgb),
		.out_last  (m_axis_tlast),
		.blend_req (blend_req),
		.blend_rsp (blend_rsp)
	);

	// Pack pixel position and spoke colors, lowest field first
	assign m_axis_tdata = {2'b00, out_rgb[3], out_rgb[2], out_rgb[1], out_rgb[0], out_pix};

endmodule

[rtl/lspg_cfg_regs.sv]
// APB register file holding the pattern mode, palette count and four palette colors.
`timescale 1ns / 1ps

module lspg_cfg_regs import lspg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg,
	output logic        mode_wr
);

	logic       wr_en;
	logic [2:0] reg_idx;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign mode_wr = wr_en && (reg_idx == REG_MODE);
	assign cfg     = cfg_q;

	// Register writes; addresses past the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode    <= MODE_CYCLE;
			cfg_q.count   <= 3'd1;
			cfg_q.palette <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MODE:   cfg_q.mode       <= pwdata[2:0];
				REG_COUNT:  cfg_q.count      <= pwdata[2:0];
				REG_COLOR0: cfg_q.palette[0] <= pwdata[RGB_W-1:0];
				REG_COLOR1: cfg_q.palette[1] <= pwdata[RGB_W-1:0];
				REG_COLOR2: cfg_q.palette[2] <= pwdata[RGB_W-1:0];
				REG_COLOR3: cfg_q.palette[3] <= pwdata[RGB_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_MODE:   prdata = {29'd0, cfg_q.mode};
			REG_COUNT:  prdata = {29'd0, cfg_q.count};
			REG_COLOR0: prdata = {8'd0, cfg_q.palette[0]};
			REG_COLOR1: prdata = {8'd0, cfg_q.palette[1]};
			REG_COLOR2: prdata = {8'd0, cfg_q.palette[2]};
			REG_COLOR3: prdata = {8'd0, cfg_q.palette[3]};
			default:    prdata = 32'd0;
		endcase
	end

endmodule

[rtl/lspg_blend_unit.sv]
// Shared one-channel blend unit: (256a + b + t*(b - a)) >> 8, registered result.
`timescale 1ns / 1ps

module lspg_blend_unit import lspg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  blend_req_t req,
	output blend_rsp_t rsp
);

	logic signed [8:0]  diff;
	logic signed [17:0] prod;
	logic signed [17:0] sum;
	blend_rsp_t         rsp_q;

	// One 9x9 signed multiply and an add per channel
	assign diff = $signed({1'b0, req.b}) - $signed({1'b0, req.a});
	assign prod = $signed({1'b0, req.amt}) * diff;
	assign sum  = $signed({2'b0, req.a, 8'd0}) + $signed({10'd0, req.b}) + prod;

	// Hold result and its destination tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_q <= '0;
		end else begin
			rsp_q.valid <= req.valid;
			rsp_q.value <= sum[15:8];
			rsp_q.spoke <= req.spoke;
			rsp_q.chan  <= req.chan;
		end
	end

	assign rsp = rsp_q;

endmodule

[rtl/lspg_frame_seq.sv]
// Frame sequencer: blend unit color setup, then one pixel per cycle unless stalled.
`timescale 1ns / 1ps

module lspg_frame_seq import lspg_pkg::*; #(
	parameter int PIXELS_PER_SPOKE = DEF_PIXELS_PER_SPOKE
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   mode_wr,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [KNOB_W-1:0]      in_knob,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [PIX_W-1:0]       out_pix,
	output logic [3:0][RGB_W-1:0]  out_rgb,
	output logic                   out_last,
	output blend_req_t             blend_req,
	input  blend_rsp_t             blend_rsp
);

	localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(PIXELS_PER_SPOKE - 1);
	localparam logic [PIX_W:0]   PIX_NUM  = (PIX_W + 1)'(PIXELS_PER_SPOKE);
	// Stripe boundaries for two, three and four stripes
	localparam logic [PIX_W-1:0] B2_1 = PIX_W'(PIXELS_PER_SPOKE / 2);
	localparam logic [PIX_W-1:0] B3_1 = PIX_W'(PIXELS_PER_SPOKE / 3);
	localparam logic [PIX_W-1:0] B3_2 = PIX_W'(2 * PIXELS_PER_SPOKE / 3);
	localparam logic [PIX_W-1:0] B4_1 = PIX_W'(PIXELS_PER_SPOKE / 4);
	localparam logic [PIX_W-1:0] B4_2 = PIX_W'(PIXELS_PER_SPOKE / 2);
	localparam logic [PIX_W-1:0] B4_3 = PIX_W'(3 * PIXELS_PER_SPOKE / 4);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_BLEND = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]               state_q;
	logic [KNOB_W-1:0]        knob_q;
	logic [PHASE_W-1:0]       phase_q;
	logic [1:0]               rot_q;
	logic [4:0]               bstep_q;
	logic [1:0]               spoke_q;
	logic [1:0]               chan_q;
	logic [PIX_W-1:0]         pix_q;
	logic [PIX_W-1:0]         kpos_q;
	logic [7:0]               wpos_q;
	logic [3:0][RGB_W-1:0]    spk_q;

	logic                     out_valid_q;
	logic [PIX_W-1:0]         out_pix_q;
	logic [3:0][RGB_W-1:0]    out_rgb_q;
	logic                     out_last_q;

	logic                     accept;
	logic                     load;
	logic                     last_pix;
	logic                     last_issue;
	logic [2:0]               cnt;
	logic [1:0]               cyc_p;
	logic [1:0]               idx1;
	logic [1:0]               idx2;
	logic [2:0]               rot_base;
	logic [CHAN_W-1:0]        amt;
	logic [RGB_W-1:0]         hue_rgb;
	logic [RGB_W-1:0]         c1;
	logic [RGB_W-1:0]         c2;
	logic [CHAN_W-1:0]        ch_a;
	logic [CHAN_W-1:0]        ch_b;
	logic [PIX_W-1:0]         stripe_start;
	logic [1:0]               stripe_idx;
	logic [3:0][RGB_W-1:0]    pix_rgb;

	assign cnt        = used_count(cfg.count);
	assign cyc_p      = mod_cnt(phase_q[2:0], cnt);
	assign hue_rgb    = wheel(knob_q[KNOB_W-1:4]);
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign load       = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign last_pix   = (pix_q == PIX_LAST);
	assign last_issue = (state_q == ST_BLEND) && (spoke_q == 2'd3) && (chan_q == CH_RED);
	assign stripe_start = PIX_W'(PIX_NUM - {1'b0, phase_q[PIX_W-1:0]});

	// Pick both sources (palette, or knob hue in hue mode) and blend amount of the spoke
	always_comb begin
		idx1     = 2'd0;
		idx2     = 2'd0;
		amt      = '0;
		rot_base = 3'd0;
		case (cfg.mode) inside
			MODE_CYCLE: begin
				idx1 = cyc_p;
				idx2 = cyc_p;
			end
			MODE_QUAD: begin
				idx1 = mod_cnt({1'b0, spoke_q}, cnt);
				idx2 = idx1;
			end
			MODE_ROTATE, MODE_MANUAL: begin
				rot_base = (cfg.mode == MODE_ROTATE) ?
					3'(spoke_q) + 3'(rot_q) : 3'(spoke_q) + 3'(knob_q[11:10]);
				idx1 = mod_cnt(rot_base, cnt);
				idx2 = mod_cnt(rot_base + 3'd1, cnt);
				amt  = (cfg.mode == MODE_ROTATE) ? {bstep_q, 3'b000} : knob_q[9:2];
			end
			default: ;
		endcase
		c1 = cfg.palette[idx1];
		c2 = cfg.palette[idx2];
		if (cfg.mode == MODE_HUE) begin
			c1 = hue_rgb;
			c2 = hue_rgb;
		end
	end

	// Channel select for the blend request
	always_comb begin
		case (chan_q)
			CH_BLUE: begin
				ch_a = c1[7:0];
				ch_b = c2[7:0];
			end
			CH_GREEN: begin
				ch_a = c1[15:8];
				ch_b = c2[15:8];
			end
			default: begin
				ch_a = c1[23:16];
				ch_b = c2[23:16];
			end
		endcase
	end

	assign blend_req.valid = (state_q == ST_BLEND);
	assign blend_req.a     = ch_a;
	assign blend_req.b     = ch_b;
	assign blend_req.amt   = amt;
	assign blend_req.spoke = spoke_q;
	assign blend_req.chan  = chan_q;

	// Stripe owning the current shifted position
	always_comb begin
		case (cnt)
			3'd2: stripe_idx = (kpos_q >= B2_1) ? 2'd1 : 2'd0;
			3'd3: stripe_idx = (kpos_q >= B3_2) ? 2'd2 : (kpos_q >= B3_1) ? 2'd1 : 2'd0;
			3'd4: stripe_idx = (kpos_q >= B4_3) ? 2'd3 : (kpos_q >= B4_2) ? 2'd2 :
				(kpos_q >= B4_1) ? 2'd1 : 2'd0;
			default: stripe_idx = 2'd0;
		endcase
	end

	// Pixel colors for the four spokes
	always_comb begin
		case (cfg.mode) inside
			MODE_STRIPE:  pix_rgb = {4{cfg.palette[stripe_idx]}};
			MODE_RAINBOW: pix_rgb = {4{wheel(wpos_q)}};
			default:      pix_rgb = spk_q;
		endcase
	end

	// Sequencer and per-frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rot_q   <= '0;
			bstep_q <= '0;
			spoke_q <= '0;
			chan_q  <= CH_BLUE;
			pix_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						spoke_q <= 2'd0;
						chan_q  <= CH_BLUE;
						state_q <= ST_BLEND;
					end
				end
				ST_BLEND: begin
					if (chan_q == CH_RED) begin
						chan_q  <= CH_BLUE;
						spoke_q <= spoke_q + 2'd1;
						// Rotate mode steps its blend once per spoke
						if (cfg.mode == MODE_ROTATE) begin
							bstep_q <= bstep_q + 5'd1;
							if (bstep_q == 5'd31) begin
								rot_q <= rot_q + 2'd1;
							end
						end
					end else begin
						chan_q <= chan_q + 2'd1;
					end
					if (last_issue) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					pix_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						pix_q <= pix_q + PIX_W'(1);
						if (last_pix) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Step the cycle/stripe/rainbow phase after the last pixel; a mode write clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (mode_wr) begin
			phase_q <= '0;
		end else if (load && last_pix) begin
			case (cfg.mode) inside
				MODE_CYCLE: phase_q <= {6'd0, mod_cnt(3'(cyc_p) + 3'd1, cnt)};
				MODE_STRIPE: phase_q <= (phase_q[PIX_W-1:0] == PIX_LAST) ?
					'0 : phase_q + 8'd1;
				MODE_RAINBOW: phase_q <= phase_q + 8'd1;
				default: ;
			endcase
		end
	end

	// Frame payload: knob, walk positions, spoke colors
	always_ff @(posedge clk) begin
		if (accept) begin
			knob_q <= in_knob;
			wpos_q <= phase_q;
			kpos_q <= (phase_q[PIX_W-1:0] == '0) ? '0 : stripe_start;
		end else if (load) begin
			wpos_q <= wpos_q + 8'd1;
			kpos_q <= (kpos_q == PIX_LAST) ? '0 : kpos_q + PIX_W'(1);
		end
		if (blend_rsp.valid) begin
			case (blend_rsp.chan)
				CH_BLUE:  spk_q[blend_rsp.spoke][7:0]   <= blend_rsp.value;
				CH_GREEN: spk_q[blend_rsp.spoke][15:8]  <= blend_rsp.value;
				default:  spk_q[blend_rsp.spoke][23:16] <= blend_rsp.value;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_pix_q  <= pix_q;
			out_rgb_q  <= pix_rgb;
			out_last_q <= last_pix;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix   = out_pix_q;
	assign out_rgb   = out_rgb_q;
	assign out_last  = out_last_q;

	// Checks
	a_stripe_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.mode == MODE_STRIPE) |-> (phase_q < 8'(PIXELS_PER_SPOKE)))
		else $error("stripe phase out of range");
	a_cycle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.mode == MODE_CYCLE) |-> (phase_q < 8'd4))
		else $error("cycle phase out of range");
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_pix_q == PIX_LAST))
		else $error("frame end on wrong pixel");
	a_frame_done: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last_pix) |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle");
	a_rsp_window: assert property (@(posedge clk) disable iff (!arst_n)
		blend_rsp.valid |-> (state_q == ST_BLEND || state_q == ST_FLUSH))
		else $error("blend result outside setup");

endmodule

[test/led_strip_pattern_generator_test.sv]
// Self-checking testbench for the LED strip pattern generator: predicts every pixel item.
`timescale 1ns / 1ps

module led_strip_pattern_generator_test;
	import lspg_pkg::*;

	localparam int PIXELS      = DEF_PIXELS_PER_SPOKE;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 136;

	// Addresses past the register list, writes there must be ignored
	localparam logic [2:0] REG_SPARE6 = 3'd6;
	localparam logic [2:0] REG_SPARE7 = 3'd7;

	// One pixel item as seen on the output stream
	typedef struct packed {
		logic [5:0]       pos;
		logic [3:0][23:0] rgb;
		logic             last;
	} pixel_t;

	// Frame predictor with its own copy of the registers and phase counters
	class pixel_scoreboard;
		logic [2:0]  mode;
		logic [2:0]  count_raw;
		logic [23:0] palette [4];
		int          phase;
		int          spoke_rot;
		int          blend_step;
		pixel_t      expected_pixels [$];
		int          errors;
		int          frames_seen;
		int          pixels_checked;

		function new();
			mode = MODE_CYCLE;
			count_raw = 3'd1;
			foreach (palette[k]) palette[k] = '0;
			phase = 0;
			spoke_rot = 0;
			blend_step = 0;
			errors = 0;
			frames_seen = 0;
			pixels_checked = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_MODE: begin
					mode = value[2:0];
					phase = 0;
				end
				REG_COUNT:  count_raw = value[2:0];
				REG_COLOR0: palette[0] = value[23:0];
				REG_COLOR1: palette[1] = value[23:0];
				REG_COLOR2: palette[2] = value[23:0];
				REG_COLOR3: palette[3] = value[23:0];
				default: ;
			endcase
		endfunction

		function logic [23:0] color_wheel(int w);
			int v;
			logic [7:0] r, g, b;
			w = w & 255;
			if (w < 85) begin
				r = 8'(3 * w); g = 8'(255 - 3 * w); b = 8'd0;
			end else if (w < 170) begin
				v = w - 85;
				r = 8'(255 - 3 * v); g = 8'd0; b = 8'(3 * v);
			end else begin
				v = w - 170;
				r = 8'd0; g = 8'(3 * v); b = 8'(255 - 3 * v);
			end
			return {r, g, b};
		endfunction

		// Channel-wise blend of c1 toward c2 by t/256
		function logic [23:0] blend_rgb(logic [23:0] c1, logic [23:0] c2, int t);
			logic [23:0] res;
			int a, b;
			for (int k = 0; k < 3; k++) begin
				a = c1[8*k +: 8];
				b = c2[8*k +: 8];
				res[8*k +: 8] = 8'((a * 256 + b + b * t - a * t) >> 8);
			end
			return res;
		endfunction

		function void predict_frame(logic [11:0] knob);
			logic [23:0] frame [4][PIXELS];
			logic [23:0] c;
			int cnt, p, lo, hi, base, amt;
			bit hit;
			pixel_t px;
			cnt = (count_raw == 3'd0) ? 1 : (count_raw > 3'd4) ? 4 : int'(count_raw);
			frames_seen++;
			case (mode)
				MODE_CYCLE: begin
					p = phase % cnt;
					for (int s = 0; s < 4; s++)
						for (int j = 0; j < PIXELS; j++) frame[s][j] = palette[p];
					phase = (p + 1) % cnt;
				end
				MODE_STRIPE: begin
					p = phase % PIXELS;
					for (int i = 0; i < cnt; i++) begin
						lo = (i * PIXELS / cnt + p) % PIXELS;
						hi = ((i + 1) * PIXELS / cnt + p) % PIXELS;
						for (int j = 0; j < PIXELS; j++) begin
							hit = (hi > lo) ? (j >= lo && j < hi) : (j < hi || j >= lo);
							if (hit)
								for (int s = 0; s < 4; s++) frame[s][j] = palette[i];
						end
					end
					phase = (p + 1) % PIXELS;
				end
				MODE_RAINBOW: begin
					for (int j = 0; j < PIXELS; j++) begin
						c = color_wheel(j + phase);
						for (int s = 0; s < 4; s++) frame[s][j] = c;
					end
					phase = (phase + 1) & 255;
				end
				MODE_SINGLE: begin
					for (int s = 0; s < 4; s++)
						for (int j = 0; j < PIXELS; j++) frame[s][j] = palette[0];
				end
				MODE_QUAD: begin
					for (int s = 0; s < 4; s++)
						for (int j = 0; j < PIXELS; j++) frame[s][j] = palette[s % cnt];
				end
				MODE_ROTATE: begin
					// Blend step advances per spoke, rotation on its wrap
					for (int s = 0; s < 4; s++) begin
						c = blend_rgb(palette[(s + spoke_rot) % cnt],
							palette[(s + spoke_rot + 1) % cnt], blend_step * 8);
						for (int j = 0; j < PIXELS; j++) frame[s][j] = c;
						blend_step = (blend_step + 1) & 31;
						if (blend_step == 0) spoke_rot = (spoke_rot + 1) & 3;
					end
				end
				MODE_HUE: begin
					c = color_wheel(int'(knob) / 16);
					for (int s = 0; s < 4; s++)
						for (int j = 0; j < PIXELS; j++) frame[s][j] = c;
				end
				default: begin
					base = int'(knob) / 1024;
					amt = (int'(knob) % 1024) / 4;
					for (int s = 0; s < 4; s++) begin
						c = blend_rgb(palette[(s + base) % cnt],
							palette[(s + base + 1) % cnt], amt);
						for (int j = 0; j < PIXELS; j++) frame[s][j] = c;
					end
				end
			endcase
			for (int j = 0; j < PIXELS; j++) begin
				px.pos = 6'(j);
				for (int s = 0; s < 4; s++) px.rgb[s] = frame[s][j];
				px.last = (j == PIXELS - 1);
				expected_pixels = {expected_pixels, px};
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (expected_pixels.size() == 0) begin
				$error("pixel item with none expected: pixel_position %0d", got.pos);
				errors++;
				return;
			end
			want = expected_pixels.pop_front();
			pixels_checked++;
			if (got.pos !== want.pos) begin
				$error("pixel_position mismatch: expected %0d, got %0d", want.pos, got.pos);
				errors++;
			end
			for (int s = 0; s < 4; s++)
				if (got.rgb[s] !== want.rgb[s]) begin
					$error("spoke%0d_rgb mismatch at pixel %0d: expected %06h, got %06h",
						s, want.pos, want.rgb[s], got.rgb[s]);
					errors++;
				end
			if (got.last !== want.last) begin
				$error("frame_end mismatch at pixel %0d: expected %0b, got %0b",
					want.pos, want.last, got.last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [4:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [15:0]  s_axis_tdata;   // [11:0] knob_value
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;   // [5:0] pixel_position, [29:6] spoke0_rgb,
	                              // [53:30] spoke1_rgb, [77:54] spoke2_rgb,
	                              // [101:78] spoke3_rgb
	logic         m_axis_tlast;   // frame_end

	pixel_scoreboard sb = new();

	int  send_idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_request = 1'b0;
	int  hold_left = 0;
	int  cycle_count = 0;
	int  random_sent = 0;
	int  phase_idx = 0;
	int  burst;

	led_strip_pattern_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("led_strip_pattern_generator_test: errors");
			$finish;
		end
	end

	// Drive output backpressure: long hold-off on request, else random stalls
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Check every accepted pixel item
	always @(posedge clk) begin : pixel_monitor
		pixel_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.pos = m_axis_tdata[5:0];
			got.rgb[0] = m_axis_tdata[29:6];
			got.rgb[1] = m_axis_tdata[53:30];
			got.rgb[2] = m_axis_tdata[77:54];
			got.rgb[3] = m_axis_tdata[101:78];
			got.last = m_axis_tlast;
			sb.check_pixel(got);
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	// Offer one frame request, then idle at random; drop valid for a gap or after the last one
	task automatic send_frame(input logic [11:0] knob, input bit last);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, knob};
		do @(posedge clk); while (!s_axis_tready);
		sb.predict_frame(knob);
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (last || gap > 0) s_axis_tvalid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	function automatic logic [11:0] pick_knob();
		case ($urandom_range(7))
			0: return 12'd0;
			1: return 12'hFFF;
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [31:0] pick_color();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_frames(input int n);
		for (int k = 0; k < n; k++) send_frame(pick_knob(), k == n - 1);
	endtask

	// Wait until every expected pixel is out, then let the block settle
	task automatic drain();
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_idle(input int idx);
		case (idx % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 61; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 61; end
			default: begin send_idle_pct = 19; stall_pct = 19; end
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: cycle mode over a black one-entry palette
		set_idle(0);
		send_frame(12'd0, 1'b1);
		drain();

		// Cycle through four extreme colors, then shrink the count under a live phase
		reg_write(REG_COLOR0, 32'hFFFF_FFFF);
		reg_write(REG_COLOR1, 32'h0000_0000);
		reg_write(REG_COLOR2, 32'h00FF_00FF);
		reg_write(REG_COLOR3, 32'h5A00_FF00);
		reg_write(REG_COUNT, 32'd4);
		reg_write(REG_MODE, {29'b0, MODE_CYCLE});
		send_frame(12'hFFF, 1'b0);
		send_frame(12'd0, 1'b0);
		send_frame(12'h800, 1'b1);
		drain();
		reg_write(REG_COUNT, 32'd2);
		send_frames(2);
		drain();
		// Zero count acts as one, counts past four saturate
		reg_write(REG_COUNT, 32'd0);
		send_frames(1);
		drain();
		reg_write(REG_COUNT, 32'hFFFF_FFFF);
		send_frames(1);
		drain();

		reg_write(REG_COUNT, 32'd3);
		reg_write(REG_MODE, {29'b0, MODE_STRIPE});
		send_frames(2);
		drain();
		reg_write(REG_MODE, {29'b0, MODE_RAINBOW});
		send_frames(2);
		drain();
		reg_write(REG_MODE, {29'b0, MODE_SINGLE});
		send_frames(1);
		drain();
		reg_write(REG_MODE, {29'b0, MODE_QUAD});
		send_frames(1);
		drain();

		// Rotate keeps its blend step and rotation across a mode rewrite
		reg_write(REG_COUNT, 32'd4);
		reg_write(REG_MODE, {29'b0, MODE_ROTATE});
		send_frames(2);
		drain();
		reg_write(REG_MODE, {29'b0, MODE_ROTATE});
		send_frames(1);
		drain();

		reg_write(REG_MODE, {29'b0, MODE_HUE});
		send_frame(12'd0, 1'b0);
		send_frame(12'hFFF, 1'b1);
		drain();
		reg_write(REG_MODE, {29'b0, MODE_MANUAL});
		send_frame(12'd0, 1'b0);
		send_frame(12'hFFF, 1'b0);
		send_frame(12'h3FF, 1'b0);
		send_frame(12'h800, 1'b1);
		drain();

		// Writes past the register list change nothing
		reg_write(REG_SPARE6, 32'hFFFF_FFFF);
		reg_write(REG_SPARE7, 32'hFFFF_FFFF);
		send_frames(1);
		drain();

		// Random settings, one idle pattern per phase; first phase fills the block
		while (random_sent < RANDOM_ITEMS) begin
			set_idle(phase_idx);
			if (phase_idx == 0 || $urandom_range(3) != 0) reg_write(REG_MODE, $urandom());
			if (phase_idx == 0 || $urandom_range(3) != 0) reg_write(REG_COUNT, $urandom());
			reg_write(REG_COLOR0, pick_color());
			reg_write(REG_COLOR1, pick_color());
			reg_write(REG_COLOR2, pick_color());
			reg_write(REG_COLOR3, pick_color());
			if (phase_idx == 0) hold_request = 1'b1;
			burst = $urandom_range(4, 12);
			send_frames(burst);
			random_sent += burst;
			phase_idx++;
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Ran %0d frame requests and checked %0d pixel items", sb.frames_seen,
			sb.pixels_checked);
		$display("over all modes, palette counts 0 to 7, random colors and backpressure");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("led_strip_pattern_generator_test: clean");
		end else begin
			if (sb.pending() != 0) $error("%0d pixel items never arrived", sb.pending());
			$display("led_strip_pattern_generator_test: errors");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/lspg_pkg.sv
rtl/lspg_cfg_regs.sv
rtl/lspg_blend_unit.sv
rtl/lspg_frame_seq.sv
rtl/led_strip_pattern_generator.sv
test/led_strip_pattern_generator_test.sv
